@@ rtl/dpi_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the damped particle integrator.
// Used by dpi_table, dpi_lane and damped_particle_integrator_unit; no dependencies.
package dpi_pkg;

  // Table geometry
  localparam int unsigned PARTICLES = 1024;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned ADDR_W    =
    ($clog2(PARTICLES) < IDX_W) ? $clog2(PARTICLES) : IDX_W;
  localparam int unsigned DEPTH     =
    (PARTICLES < (2 ** IDX_W)) ? PARTICLES : (2 ** IDX_W);

  // Field widths
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned DT_W       = 24;
  localparam int unsigned FAC_W      = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = DT_W;
  localparam int unsigned TYPE_W     = 2;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned REQ_W        = IDX_W + 9 * VAL_W;
  localparam int unsigned IN_TDATA_W   = ((REQ_W + 7) / 8) * 8;
  localparam int unsigned RES_W        = IDX_W + 6 * VAL_W;
  localparam int unsigned OUT_TDATA_W  = ((RES_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - RES_W;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_TIME = 2'd0,
    CFG_KEEP      = 2'd1,
    CFG_SCALE     = 2'd2
  } cfg_idx_e;

  localparam logic [DT_W-1:0]  STEP_TIME_RST = 24'd16777;
  localparam logic [FAC_W-1:0] KEEP_RST      = 17'd65529;
  localparam logic [FAC_W-1:0] SCALE_RST     = 17'd65530;

  // Request kinds
  typedef enum logic [TYPE_W-1:0] {
    REQ_LOAD      = 2'd0,
    REQ_INTEGRATE = 2'd1,
    REQ_CONTROL   = 2'd2
  } req_e;

  // Lane sequencer steps, at most one multiply per step
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_KEEP  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_FORCE = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DT_LO = 4'd2;
  localparam logic [STEP_W-1:0] STEP_DT_HI = 4'd3;
  localparam logic [STEP_W-1:0] STEP_T2    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SUM   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SC_LO = 4'd6;
  localparam logic [STEP_W-1:0] STEP_SC_HI = 4'd7;
  localparam logic [STEP_W-1:0] STEP_VEL   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_ADV   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_POS   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_POS;

  // Configuration as seen by the lanes
  typedef struct packed {
    logic [DT_W-1:0]  dt;
    logic [FAC_W-1:0] keep;
    logic [FAC_W-1:0] scale;
  } cfg_t;

  // Sequencer to lane control
  typedef struct packed {
    logic              run;
    logic [STEP_W-1:0] step;
    logic              use_ctl;
  } lane_ctl_t;

  // Lane result
  typedef struct packed {
    logic [VAL_W-1:0] pos;
    logic [VAL_W-1:0] vel;
    logic             sat;
  } lane_res_t;

  // One particle table entry
  typedef struct packed {
    logic [VAL_W-1:0] inv_inertia;
    logic [VAL_W-1:0] inv_mass;
    logic [VAL_W-1:0] spin;
    logic [VAL_W-1:0] vel_y;
    logic [VAL_W-1:0] vel_x;
    logic [VAL_W-1:0] angle;
    logic [VAL_W-1:0] pos_y;
    logic [VAL_W-1:0] pos_x;
  } entry_t;

endpackage

@@ rtl/dpi_table.sv @@
`timescale 1ns / 1ps
// Particle state table: one synchronous memory, one write and one read port.
// Depends on dpi_pkg for the entry layout and depth.
module dpi_table (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [dpi_pkg::ADDR_W-1:0] wr_addr_i,
  input  dpi_pkg::entry_t            wr_data_i,
  input  logic                       rd_en_i,
  input  logic [dpi_pkg::ADDR_W-1:0] rd_addr_i,
  output dpi_pkg::entry_t            rd_data_o
);

  dpi_pkg::entry_t mem_q [dpi_pkg::DEPTH];
  dpi_pkg::entry_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port, holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/dpi_lane.sv @@
`timescale 1ns / 1ps
// One update lane: damped velocity and position step on a shared 32x32 multiplier.
// Depends on dpi_pkg for step codes, configuration and result types.
module dpi_lane (
  input  logic                      clk_i,
  input  dpi_pkg::cfg_t             cfg_i,
  input  dpi_pkg::lane_ctl_t        ctl_i,
  input  logic [dpi_pkg::VAL_W-1:0] vel_i,
  input  logic [dpi_pkg::VAL_W-1:0] force_i,
  input  logic [dpi_pkg::VAL_W-1:0] inv_i,
  input  logic [dpi_pkg::VAL_W-1:0] pos_i,
  input  logic [dpi_pkg::VAL_W-1:0] ctrl_vel_i,
  output dpi_pkg::lane_res_t        res_o
);

  function automatic logic [31:0] magnitude(logic [31:0] bits);
    magnitude = bits[31] ? (~bits + 32'd1) : bits;
  endfunction

  logic [31:0] v_mag, f_mag, adv_bits, adv_mag;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, prod_q;

  logic [47:0] t1_q;
  logic [62:0] p_q;
  logic [55:0] qlo_q;
  logic [63:0] t2_q;
  logic [63:0] s_q, s_d;
  logic        s_neg_q, s_neg_d;
  logic [48:0] slo_q;
  logic [31:0] vel_q, vel_d;
  logic        sat_v_q, sat_v_d;
  logic [31:0] pos_q, pos_d;
  logic        sat_p_q, sat_p_d;

  logic [87:0] t2_sum;
  logic        n1, n2;
  logic [63:0] t1_ext;
  logic [49:0] slo_sum, sc_mag;
  logic [56:0] d_sum;
  logic [34:0] pos_ext, d_ext, pos_sum;

  assign v_mag    = magnitude(vel_i);
  assign f_mag    = magnitude(force_i);
  assign adv_bits = ctl_i.use_ctl ? ctrl_vel_i : vel_q;
  assign adv_mag  = magnitude(adv_bits);

  // Pick multiplier operands for the current step
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (ctl_i.step)
      dpi_pkg::STEP_KEEP: begin
        mul_a = v_mag;
        mul_b = 32'(cfg_i.keep);
      end
      dpi_pkg::STEP_FORCE: begin
        mul_a = f_mag;
        mul_b = inv_i;
      end
      dpi_pkg::STEP_DT_LO: begin
        mul_a = prod_q[31:0];
        mul_b = 32'(cfg_i.dt);
      end
      dpi_pkg::STEP_DT_HI: begin
        mul_a = {1'b0, p_q[62:32]};
        mul_b = 32'(cfg_i.dt);
      end
      dpi_pkg::STEP_SC_LO: begin
        mul_a = s_q[31:0];
        mul_b = 32'(cfg_i.scale);
      end
      dpi_pkg::STEP_SC_HI: begin
        mul_a = s_q[63:32];
        mul_b = 32'(cfg_i.scale);
      end
      dpi_pkg::STEP_ADV: begin
        mul_a = adv_mag;
        mul_b = 32'(cfg_i.dt);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Force term times dt, rounded half away from zero to Q.32
  assign t2_sum = 88'({prod_q[54:0], 32'd0}) + 88'(qlo_q) + 88'h80_0000;

  // Signed sum of the damped velocity and the force term
  assign t1_ext = 64'(t1_q);
  assign n1     = vel_i[31] && (t1_q != 48'd0);
  assign n2     = force_i[31] && (t2_q != 64'd0);

  always_comb begin
    if (n1 == n2) begin
      s_d     = t1_ext + t2_q;
      s_neg_d = n1;
    end else if (t1_ext >= t2_q) begin
      s_d     = t1_ext - t2_q;
      s_neg_d = n1;
    end else begin
      s_d     = t2_q - t1_ext;
      s_neg_d = n2;
    end
  end

  // Scale by damp_scale, round to Q15.16 and clip
  assign slo_sum = 50'(slo_q) + 50'h0_8000_0000;
  assign sc_mag  = 50'(prod_q[48:0]) + {32'd0, slo_sum[49:32]};

  always_comb begin
    sat_v_d = 1'b0;
    if (!s_neg_q) begin
      if (sc_mag > 50'h0_7FFF_FFFF) begin
        vel_d   = 32'h7FFF_FFFF;
        sat_v_d = 1'b1;
      end else begin
        vel_d = sc_mag[31:0];
      end
    end else begin
      if (sc_mag > 50'h0_8000_0000) begin
        vel_d   = 32'h8000_0000;
        sat_v_d = 1'b1;
      end else begin
        vel_d = ~sc_mag[31:0] + 32'd1;
      end
    end
  end

  // Position step: round v*dt, add with sign, clip to 32 bits
  assign d_sum   = 57'(prod_q[55:0]) + 57'h80_0000;
  assign pos_ext = {{3{pos_i[31]}}, pos_i};
  assign d_ext   = {2'b00, d_sum[56:24]};
  assign pos_sum = adv_bits[31] ? (pos_ext - d_ext) : (pos_ext + d_ext);

  always_comb begin
    sat_p_d = 1'b0;
    if ((pos_sum[34:31] == 4'b0000) || (pos_sum[34:31] == 4'b1111)) begin
      pos_d = pos_sum[31:0];
    end else if (pos_sum[34]) begin
      pos_d   = 32'h8000_0000;
      sat_p_d = 1'b1;
    end else begin
      pos_d   = 32'h7FFF_FFFF;
      sat_p_d = 1'b1;
    end
  end

  // Register the product every cycle
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
  end

  // Capture intermediate values at their step
  always_ff @(posedge clk_i) begin
    if (ctl_i.run) begin
      case (ctl_i.step)
        dpi_pkg::STEP_FORCE: t1_q  <= prod_q[47:0];
        dpi_pkg::STEP_DT_LO: p_q   <= prod_q[62:0];
        dpi_pkg::STEP_DT_HI: qlo_q <= prod_q[55:0];
        dpi_pkg::STEP_T2:    t2_q  <= t2_sum[87:24];
        dpi_pkg::STEP_SUM: begin
          s_q     <= s_d;
          s_neg_q <= s_neg_d;
        end
        dpi_pkg::STEP_SC_HI: slo_q <= prod_q[48:0];
        dpi_pkg::STEP_VEL: begin
          vel_q   <= vel_d;
          sat_v_q <= sat_v_d;
        end
        dpi_pkg::STEP_POS: begin
          pos_q   <= pos_d;
          sat_p_q <= sat_p_d;
        end
        default: begin
        end
      endcase
    end
  end

  assign res_o.pos = pos_q;
  assign res_o.vel = vel_q;
  assign res_o.sat = sat_v_q | sat_p_q;

endmodule

@@ rtl/damped_particle_integrator_unit.sv @@
`timescale 1ns / 1ps
// Top level: request stream, config registers, sequencer, table and three lanes.
// Depends on dpi_pkg, dpi_table and dpi_lane.
//
//  Channel   Direction  Payload (lowest bits first)
//  s_axis    in         tdata: index, force x/y, torque, x vel control, load pos x/y,
//                       load rotation, load inv mass, load inv inertia; tuser: req type
//  m_axis    out        tdata: index, pos x/y, vel x/y, angle, spin; tuser: saturated
//  cfg       in         we, register index, data (step time, keep, damp scale)
//
// An integrate item keeps the block busy from accept to result, so no new item is taken:
// one memory read, eleven lane steps sharing the 32x32 multiplier of each lane, one write back.
// A load skips the lane steps. Dropped items (type 3, index out of range) give no result.
// The table needs no clearing after reset; reset restores the config defaults.
// A stalled result is held in the output register while the next item is accepted;
// the write back of that next item waits until the output register frees.
module damped_particle_integrator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // index, force_x, force_y, torque, x_velocity_control, load_pos_x, load_pos_y,
  // load_rotation, load_inv_mass, load_inv_inertia
  input  logic [dpi_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // req_type
  input  logic [dpi_pkg::TYPE_W-1:0]       s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_index, pos_x, pos_y, vel_x, vel_y, angle, spin
  output logic [dpi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // saturated
  output logic                             m_axis_tuser,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [dpi_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [dpi_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic [31:0]               inv_inertia;
    logic [31:0]               inv_mass;
    logic [31:0]               rotation;
    logic [31:0]               pos_y;
    logic [31:0]               pos_x;
    logic [31:0]               ctrl_vel;
    logic [31:0]               torque;
    logic [31:0]               force_y;
    logic [31:0]               force_x;
    logic [dpi_pkg::IDX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [31:0]               spin;
    logic [31:0]               angle;
    logic [31:0]               vel_y;
    logic [31:0]               vel_x;
    logic [31:0]               pos_y;
    logic [31:0]               pos_x;
    logic [dpi_pkg::IDX_W-1:0] index;
  } res_t;

  state_e                        state_q, state_d;
  logic [dpi_pkg::STEP_W-1:0]    step_q, step_d;
  dpi_pkg::req_e                 req_type_q, in_type;
  req_t                          req_q, in_req;
  dpi_pkg::cfg_t                 cfg_q;
  logic                          in_fire, idx_ok, out_free, done_fire;
  logic                          m_valid_q;
  res_t                          m_data_q, res_d;
  logic                          m_user_q, sat_d;
  dpi_pkg::entry_t               rd_data, wr_entry;
  dpi_pkg::lane_ctl_t            ctl_x, ctl_other;
  dpi_pkg::lane_res_t            res_x, res_y, res_w;

  assign in_req   = req_t'(s_axis_tdata[dpi_pkg::REQ_W-1:0]);
  assign in_type  = dpi_pkg::req_e'(s_axis_tuser);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign idx_ok   = (32'(in_req.index) < dpi_pkg::PARTICLES);
  assign out_free = !m_valid_q || m_axis_tready;
  assign done_fire = (state_q == ST_DONE) && out_free;

  assign s_axis_tready = (state_q == ST_IDLE);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dt    <= dpi_pkg::STEP_TIME_RST;
      cfg_q.keep  <= dpi_pkg::KEEP_RST;
      cfg_q.scale <= dpi_pkg::SCALE_RST;
    end else if (cfg_we_i) begin
      case (dpi_pkg::cfg_idx_e'(cfg_addr_i))
        dpi_pkg::CFG_STEP_TIME: cfg_q.dt    <= cfg_wdata_i;
        dpi_pkg::CFG_KEEP:      cfg_q.keep  <= cfg_wdata_i[dpi_pkg::FAC_W-1:0];
        dpi_pkg::CFG_SCALE:     cfg_q.scale <= cfg_wdata_i[dpi_pkg::FAC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    step_d  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && idx_ok) begin
          case (in_type)
            dpi_pkg::REQ_LOAD:      state_d = ST_DONE;
            dpi_pkg::REQ_INTEGRATE: state_d = ST_CALC;
            dpi_pkg::REQ_CONTROL:   state_d = ST_CALC;
            default:                state_d = ST_IDLE;
          endcase
        end
      end
      ST_CALC: begin
        if (step_q == dpi_pkg::STEP_LAST) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      req_type_q <= dpi_pkg::REQ_LOAD;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (in_fire) begin
        req_type_q <= in_type;
      end
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_req;
    end
  end

  // Particle table: read on accept, write back when the result enters the output register
  dpi_table u_table (
    .clk_i     (clk_i),
    .wr_en_i   (done_fire),
    .wr_addr_i (req_q.index[dpi_pkg::ADDR_W-1:0]),
    .wr_data_i (wr_entry),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_req.index[dpi_pkg::ADDR_W-1:0]),
    .rd_data_o (rd_data)
  );

  // Lane control
  always_comb begin
    ctl_x.run       = (state_q == ST_CALC);
    ctl_x.step      = step_q;
    ctl_x.use_ctl   = (req_type_q == dpi_pkg::REQ_CONTROL);
    ctl_other       = ctl_x;
    ctl_other.use_ctl = 1'b0;
  end

  dpi_lane u_lane_x (
    .clk_i      (clk_i),
    .cfg_i      (cfg_q),
    .ctl_i      (ctl_x),
    .vel_i      (rd_data.vel_x),
    .force_i    (req_q.force_x),
    .inv_i      (rd_data.inv_mass),
    .pos_i      (rd_data.pos_x),
    .ctrl_vel_i (req_q.ctrl_vel),
    .res_o      (res_x)
  );

  dpi_lane u_lane_y (
    .clk_i      (clk_i),
    .cfg_i      (cfg_q),
    .ctl_i      (ctl_other),
    .vel_i      (rd_data.vel_y),
    .force_i    (req_q.force_y),
    .inv_i      (rd_data.inv_mass),
    .pos_i      (rd_data.pos_y),
    .ctrl_vel_i (32'd0),
    .res_o      (res_y)
  );

  dpi_lane u_lane_w (
    .clk_i      (clk_i),
    .cfg_i      (cfg_q),
    .ctl_i      (ctl_other),
    .vel_i      (rd_data.spin),
    .force_i    (req_q.torque),
    .inv_i      (rd_data.inv_inertia),
    .pos_i      (rd_data.angle),
    .ctrl_vel_i (32'd0),
    .res_o      (res_w)
  );

  // Build the new entry and the result item
  always_comb begin
    if (req_type_q == dpi_pkg::REQ_LOAD) begin
      wr_entry.pos_x       = req_q.pos_x;
      wr_entry.pos_y       = req_q.pos_y;
      wr_entry.angle       = req_q.rotation;
      wr_entry.vel_x       = 32'd0;
      wr_entry.vel_y       = 32'd0;
      wr_entry.spin        = 32'd0;
      wr_entry.inv_mass    = req_q.inv_mass;
      wr_entry.inv_inertia = req_q.inv_inertia;
      sat_d                = 1'b0;
    end else begin
      wr_entry.pos_x       = res_x.pos;
      wr_entry.pos_y       = res_y.pos;
      wr_entry.angle       = res_w.pos;
      wr_entry.vel_x       = res_x.vel;
      wr_entry.vel_y       = res_y.vel;
      wr_entry.spin        = res_w.vel;
      wr_entry.inv_mass    = rd_data.inv_mass;
      wr_entry.inv_inertia = rd_data.inv_inertia;
      sat_d                = res_x.sat | res_y.sat | res_w.sat;
    end
    res_d.index = req_q.index;
    res_d.pos_x = wr_entry.pos_x;
    res_d.pos_y = wr_entry.pos_y;
    res_d.vel_x = wr_entry.vel_x;
    res_d.vel_y = wr_entry.vel_y;
    res_d.angle = wr_entry.angle;
    res_d.spin  = wr_entry.spin;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (done_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      m_data_q <= res_d;
      m_user_q <= sat_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{dpi_pkg::OUT_PAD_W{1'b0}}, m_data_q};
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTHESIS
  // An accepted integrate or control item starts the lanes at the first step
  a_integrate_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && idx_ok &&
     (in_type == dpi_pkg::REQ_INTEGRATE || in_type == dpi_pkg::REQ_CONTROL))
    |=> (state_q == ST_CALC && step_q == '0))
    else $error("integrate item did not start the lane steps");

  // A new result appears only after the write-back state
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result appeared without write back");

  // Read data feeding the lanes holds for the whole computation
  a_read_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC && step_q != '0) |-> $stable(rd_data))
    else $error("table read data changed during computation");

  // The step counter runs only while computing
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != '0) |-> (state_q == ST_CALC))
    else $error("step counter active outside computation");

  // A load result carries zero velocities and no saturation
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && req_type_q == dpi_pkg::REQ_LOAD)
    |=> (!m_user_q && m_data_q.vel_x == 32'd0 && m_data_q.vel_y == 32'd0 &&
         m_data_q.spin == 32'd0))
    else $error("load result has nonzero velocity or saturation");
`endif

endmodule

@@ sim/damped_particle_integrator_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for damped_particle_integrator_unit: a directed table, then random
// request streams over several register settings, checked by a built-in particle predictor.
// Depends on dpi_pkg and the RTL of damped_particle_integrator_unit.
module damped_particle_integrator_unit_tb;
  import dpi_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int DRAIN_CYCLES    = 30;
  localparam int TIMEOUT_NS      = 1_000_000;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [IDX_W-1:0]  index;
    logic [31:0]       force_x;
    logic [31:0]       force_y;
    logic [31:0]       torque;
    logic [31:0]       x_vel_ctl;
    logic [31:0]       pos_x;
    logic [31:0]       pos_y;
    logic [31:0]       rotation;
    logic [31:0]       inv_mass;
    logic [31:0]       inv_inertia;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [31:0]      pos_x;
    logic [31:0]      pos_y;
    logic [31:0]      vel_x;
    logic [31:0]      vel_y;
    logic [31:0]      angle;
    logic [31:0]      spin;
    logic             sat;
  } particle_state_t;

  typedef struct packed {
    logic            fixed;
    request_t        req;
    particle_state_t want;
  } plan_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  // index, force_x, force_y, torque, x_velocity_control, load_pos_x, load_pos_y,
  // load_rotation, load_inv_mass, load_inv_inertia
  logic [IN_TDATA_W-1:0]       s_axis_tdata;
  // req_type
  logic [TYPE_W-1:0]           s_axis_tuser;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  // out_index, pos_x, pos_y, vel_x, vel_y, angle, spin
  logic [OUT_TDATA_W-1:0]      m_axis_tdata;
  // saturated
  logic                        m_axis_tuser;
  logic                        cfg_we_i;
  logic [CFG_IDX_W-1:0]        cfg_addr_i;
  logic [CFG_DATA_W-1:0]       cfg_wdata_i;

  // Predictor copy of the particle table and registers
  logic [31:0]      part_pos_x[PARTICLES];
  logic [31:0]      part_pos_y[PARTICLES];
  logic [31:0]      part_vel_x[PARTICLES];
  logic [31:0]      part_vel_y[PARTICLES];
  logic [31:0]      part_angle[PARTICLES];
  logic [31:0]      part_spin[PARTICLES];
  logic [31:0]      part_inv_mass[PARTICLES];
  logic [31:0]      part_inv_inertia[PARTICLES];
  bit               part_loaded[PARTICLES];
  logic [IDX_W-1:0] live_ids[$];
  logic [DT_W-1:0]  cfg_dt    = STEP_TIME_RST;
  logic [FAC_W-1:0] cfg_keep  = KEEP_RST;
  logic [FAC_W-1:0] cfg_scale = SCALE_RST;

  particle_state_t expected_states[$];
  plan_row_t       directed_plan[$];
  bit              steady = 1'b0;
  int unsigned     fault_count = 0;
  int unsigned     n_results = 0;
  int unsigned     n_saturated = 0;
  int unsigned     n_loads = 0;
  int unsigned     n_integrates = 0;
  int unsigned     n_controls = 0;
  int unsigned     n_ignored = 0;

  damped_particle_integrator_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Magnitude of a Q15.16 value; the most negative value maps to 2^31
  function automatic logic [63:0] magnitude(input logic [31:0] b);
    return b[31] ? {32'd0, 32'd0 - b} : {32'd0, b};
  endfunction

  // m * dt / 2^24, rounded half away from zero
  function automatic logic [63:0] times_dt(input logic [63:0] m);
    logic [63:0] dt64;
    logic [63:0] lo;
    dt64 = 64'(cfg_dt);
    lo   = 64'(m[23:0]);
    return (m >> 24) * dt64 + ((lo * dt64 + 64'h80_0000) >> 24);
  endfunction

  // Clip a sign and magnitude to the signed 32-bit range
  function automatic logic [31:0] clip_q16(input logic neg, input logic [63:0] mag,
                                           inout logic sat);
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        sat = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return mag[31:0];
    end
    if (mag > 64'h8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return 32'd0 - mag[31:0];
  endfunction

  // (v * keep + f * inv * dt) * scale, back to Q15.16
  function automatic logic [31:0] damp_velocity(input logic [31:0] v, input logic [31:0] f,
                                                input logic [31:0] inv, inout logic sat);
    logic [63:0] t1, t2, s, hi, lo;
    logic        n1, n2, sn;
    t1 = magnitude(v) * 64'(cfg_keep);
    t2 = times_dt(magnitude(f) * 64'(inv));
    n1 = v[31] && (t1 != 0);
    n2 = f[31] && (t2 != 0);
    if (n1 == n2) begin
      sn = n1;
      s  = t1 + t2;
    end else if (t1 >= t2) begin
      sn = n1;
      s  = t1 - t2;
    end else begin
      sn = n2;
      s  = t2 - t1;
    end
    hi = s >> 32;
    lo = s & 64'hFFFF_FFFF;
    s  = hi * 64'(cfg_scale) + ((lo * 64'(cfg_scale) + 64'h8000_0000) >> 32);
    if (s == 0) sn = 1'b0;
    return clip_q16(sn, s, sat);
  endfunction

  // p + v * dt, saturated
  function automatic logic [31:0] step_position(input logic [31:0] p, input logic [31:0] v,
                                                inout logic sat);
    longint d, sum;
    d   = longint'(times_dt(magnitude(v)));
    sum = longint'($signed(p));
    sum = v[31] ? sum - d : sum + d;
    return clip_q16(sum < 0, (sum < 0) ? 64'(-sum) : 64'(sum), sat);
  endfunction

  // Apply one request to the table copy; returns 1 when the block owes a result
  function automatic logic predict_update(input request_t r, output particle_state_t s);
    logic        sat;
    logic [31:0] vx, vy, w, xv;
    int unsigned i;
    sat = 1'b0;
    s   = '0;
    i   = 32'(r.index);
    if (r.kind == REQ_UNUSED || i >= PARTICLES) return 1'b0;
    if (r.kind == REQ_LOAD) begin
      part_pos_x[i]       = r.pos_x;
      part_pos_y[i]       = r.pos_y;
      part_angle[i]       = r.rotation;
      part_inv_mass[i]    = r.inv_mass;
      part_inv_inertia[i] = r.inv_inertia;
      part_vel_x[i]       = '0;
      part_vel_y[i]       = '0;
      part_spin[i]        = '0;
      if (!part_loaded[i]) live_ids.push_back(r.index);
      part_loaded[i] = 1'b1;
    end else begin
      vx = damp_velocity(part_vel_x[i], r.force_x, part_inv_mass[i], sat);
      vy = damp_velocity(part_vel_y[i], r.force_y, part_inv_mass[i], sat);
      w  = damp_velocity(part_spin[i], r.torque, part_inv_inertia[i], sat);
      xv = (r.kind == REQ_CONTROL) ? r.x_vel_ctl : vx;
      part_vel_x[i] = vx;
      part_vel_y[i] = vy;
      part_spin[i]  = w;
      part_pos_x[i] = step_position(part_pos_x[i], xv, sat);
      part_pos_y[i] = step_position(part_pos_y[i], vy, sat);
      part_angle[i] = step_position(part_angle[i], w, sat);
    end
    s = '{index: r.index, pos_x: part_pos_x[i], pos_y: part_pos_y[i], vel_x: part_vel_x[i],
          vel_y: part_vel_y[i], angle: part_angle[i], spin: part_spin[i], sat: sat};
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic request_t make_request(
    input logic [TYPE_W-1:0] kind, input logic [IDX_W-1:0] index,
    input logic [31:0] fx, input logic [31:0] fy, input logic [31:0] tq,
    input logic [31:0] xvc, input logic [31:0] px, input logic [31:0] py,
    input logic [31:0] rot, input logic [31:0] im, input logic [31:0] ii);
    return '{kind: kind, index: index, force_x: fx, force_y: fy, torque: tq,
             x_vel_ctl: xvc, pos_x: px, pos_y: py, rotation: rot, inv_mass: im,
             inv_inertia: ii};
  endfunction

  function automatic particle_state_t make_state(
    input logic [IDX_W-1:0] index, input logic [31:0] px, input logic [31:0] py,
    input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] ang,
    input logic [31:0] w, input logic sat);
    return '{index: index, pos_x: px, pos_y: py, vel_x: vx, vel_y: vy, angle: ang,
             spin: w, sat: sat};
  endfunction

  // Mix of extremes, full-range noise and values near zero
  function automatic logic [31:0] random_q16();
    logic [17:0] near;
    near = 18'($urandom());
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3, 4, 5: return $urandom();
      default: return {{14{near[17]}}, near};
    endcase
  endfunction

  function automatic logic [31:0] random_inverse();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      default: return $urandom_range(32'h0000_1000, 32'h0004_0000);
    endcase
  endfunction

  // Mostly integrate loaded particles, favoring recently loaded ones so that
  // velocity builds up over several steps
  function automatic request_t random_request();
    request_t    r;
    int unsigned n, pick, span;
    r = make_request(REQ_INTEGRATE, '0, random_q16(), random_q16(), random_q16(),
                     random_q16(), random_q16(), random_q16(), random_q16(),
                     random_inverse(), random_inverse());
    n    = live_ids.size();
    pick = $urandom_range(0, 99);
    if (n < 4 || pick < 18) begin
      r.kind  = REQ_LOAD;
      r.index = (n > 0 && $urandom_range(0, 1) == 1) ? live_ids[$urandom_range(0, n - 1)]
                                                      : IDX_W'($urandom());
    end else if (pick < 22) begin
      r.kind  = REQ_UNUSED;
      r.index = IDX_W'($urandom());
    end else begin
      r.kind = (pick < 77) ? REQ_INTEGRATE : REQ_CONTROL;
      span   = (n < 8) ? n : 8;
      if ($urandom_range(0, 9) < 7) r.index = live_ids[n - 1 - $urandom_range(0, span - 1)];
      else r.index = live_ids[$urandom_range(0, n - 1)];
    end
    return r;
  endfunction

  // Present one item, wait for the handshake, then book its expected result
  task automatic send_request(input request_t r, input logic fixed,
                              input particle_state_t want);
    particle_state_t outcome;
    @(negedge clk_i);
    if (!steady && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    s_axis_tuser = r.kind;
    s_axis_tdata = '0;
    s_axis_tdata[REQ_W-1:0] = {r.inv_inertia, r.inv_mass, r.rotation, r.pos_y, r.pos_x,
                               r.x_vel_ctl, r.torque, r.force_y, r.force_x, r.index};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    case (r.kind)
      REQ_LOAD:      n_loads++;
      REQ_INTEGRATE: n_integrates++;
      REQ_CONTROL:   n_controls++;
      default:       n_ignored++;
    endcase
    if (predict_update(r, outcome)) expected_states.push_back(fixed ? want : outcome);
  endtask

  // Wait until the block is idle
  task automatic drain_block();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_states.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = data;
  endtask

  task automatic program_registers(input logic [DT_W-1:0] dt, input logic [FAC_W-1:0] keep,
                                   input logic [FAC_W-1:0] scale);
    drain_block();
    write_register(CFG_STEP_TIME, CFG_DATA_W'(dt));
    write_register(CFG_KEEP, CFG_DATA_W'(keep));
    write_register(CFG_SCALE, CFG_DATA_W'(scale));
    @(negedge clk_i);
    cfg_we_i  = 1'b0;
    cfg_dt    = dt;
    cfg_keep  = keep;
    cfg_scale = scale;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
        $display("%0t: result %0d field %s: expected %h, got %h",
                 $realtime, n_results, name, want, got);
    end
  endfunction

  // Compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    particle_state_t want;
    particle_state_t seen;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.index = m_axis_tdata[IDX_W-1:0];
      seen.pos_x = m_axis_tdata[IDX_W +: VAL_W];
      seen.pos_y = m_axis_tdata[IDX_W + VAL_W +: VAL_W];
      seen.vel_x = m_axis_tdata[IDX_W + 2 * VAL_W +: VAL_W];
      seen.vel_y = m_axis_tdata[IDX_W + 3 * VAL_W +: VAL_W];
      seen.angle = m_axis_tdata[IDX_W + 4 * VAL_W +: VAL_W];
      seen.spin  = m_axis_tdata[IDX_W + 5 * VAL_W +: VAL_W];
      seen.sat   = m_axis_tuser;
      if (expected_states.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("%0t: unexpected result for particle %0d", $realtime, seen.index);
      end else begin
        want = expected_states.pop_front();
        check_field("out_index", 32'(want.index), 32'(seen.index));
        check_field("pos_x", want.pos_x, seen.pos_x);
        check_field("pos_y", want.pos_y, seen.pos_y);
        check_field("vel_x", want.vel_x, seen.vel_x);
        check_field("vel_y", want.vel_y, seen.vel_y);
        check_field("angle", want.angle, seen.angle);
        check_field("spin", want.spin, seen.spin);
        check_field("saturated", 32'(want.sat), 32'(seen.sat));
        if (seen.sat) n_saturated++;
      end
      n_results++;
    end
  end

  // Stall the result side in random bursts
  initial begin : result_pacing
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        m_axis_tready = 1'b0;
        hold--;
      end else if (!steady && $urandom_range(0, 99) < 12) begin
        m_axis_tready = 1'b0;
        hold = $urandom_range(1, 14) - 1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Hard stop
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("damped_particle_integrator_unit test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    plan_row_t       row;
    particle_state_t blank;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b1;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = CFG_STEP_TIME;
    cfg_wdata_i   = '0;
    blank         = '0;

    // Directed rows, run with the reset register values. Loads and the
    // zero-inverse integrate are typed in; the rest go through the predictor.
    directed_plan.push_back({1'b1,
      make_request(REQ_LOAD, 10'd0, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      make_state(10'd0, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0, '0, 1'b0)});
    directed_plan.push_back({1'b1,
      make_request(REQ_LOAD, 10'd1023, '0, '0, '0, '0,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000),
      make_state(10'd1023, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, 32'h7FFF_FFFF, '0, 1'b0)});
    directed_plan.push_back({1'b1,
      make_request(REQ_LOAD, 10'h155, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   '0, '0, '0, '0, '0),
      make_state(10'h155, '0, '0, '0, '0, '0, '0, 1'b0)});
    directed_plan.push_back({1'b1,
      make_request(REQ_LOAD, 10'h2AA, '0, '0, '0, '0,
                   32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000, 32'h0002_0000),
      make_state(10'h2AA, 32'h0001_0000, 32'hFFFF_0000, '0, '0, 32'h0000_8000, '0, 1'b0)});
    // zero inverse mass and inertia: full-scale forces move nothing
    directed_plan.push_back({1'b1,
      make_request(REQ_INTEGRATE, 10'h155, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, '0, '0, '0, '0, '0),
      make_state(10'h155, '0, '0, '0, '0, '0, '0, 1'b0)});
    directed_plan.push_back({1'b0,
      make_request(REQ_INTEGRATE, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0,
                   '0, '0, '0, '0, '0), blank});
    directed_plan.push_back({1'b0,
      make_request(REQ_CONTROL, 10'd1023, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0000, '0, '0, '0, '0, '0), blank});
    directed_plan.push_back({1'b0,
      make_request(REQ_CONTROL, 10'd1023, '0, '0, '0, 32'h7FFF_FFFF, '0, '0, '0, '0, '0),
      blank});
    // unused request kind: dropped, no result
    directed_plan.push_back({1'b0,
      make_request(REQ_UNUSED, 10'd0, '1, '1, '1, '1, '1, '1, '1, '1, '1), blank});
    directed_plan.push_back({1'b0,
      make_request(REQ_INTEGRATE, 10'h2AA, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, '0,
                   '0, '0, '0, '0, '0), blank});
    directed_plan.push_back({1'b0,
      make_request(REQ_INTEGRATE, 10'h2AA, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, '0,
                   '0, '0, '0, '0, '0), blank});
    directed_plan.push_back({1'b0,
      make_request(REQ_CONTROL, 10'h2AA, 32'hFFFF_FFFF, '0, '0, 32'hFFFF_0000,
                   '0, '0, '0, '0, '0), blank});
    // reload clears velocity and spin
    directed_plan.push_back({1'b1,
      make_request(REQ_LOAD, 10'd0, '0, '0, '0, '0,
                   '0, '0, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000),
      make_state(10'd0, '0, '0, '0, '0, 32'h8000_0000, '0, 1'b0)});
    directed_plan.push_back({1'b0,
      make_request(REQ_INTEGRATE, 10'd0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, '0,
                   '0, '0, '0, '0, '0), blank});
    directed_plan.push_back({1'b0,
      make_request(REQ_UNUSED, 10'd1023, '0, '0, '0, '0, '0, '0, '0, '0, '0), blank});
    directed_plan.push_back({1'b0,
      make_request(REQ_INTEGRATE, 10'd1023, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0,
                   '0, '0, '0, '0, '0), blank});

    // Reset
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table
    foreach (directed_plan[k]) begin
      row = directed_plan[k];
      send_request(row.req, row.fixed, row.want);
    end

    // Random streams under several register settings; the last runs without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_registers(24'd16777, 17'd65529, 17'd65530);
        1: program_registers(24'hFF_FFFF, 17'd65536, 17'd65536);
        2: program_registers(24'd0, 17'd0, 17'd0);
        3: program_registers(DT_W'($urandom()), 17'h1_FFFF, 17'h1_FFFF);
        4: program_registers(24'd1, 17'd65536, 17'd1);
        default: program_registers(DT_W'($urandom_range(1, 24'h2_0000)),
                                   FAC_W'($urandom_range(60000, 65536)),
                                   FAC_W'($urandom_range(60000, 65536)));
      endcase
      steady = (ph == PHASES - 1);
      repeat (ITEMS_PER_PHASE) send_request(random_request(), 1'b0, '0);
    end

    drain_block();
    $display("Summary: %0d results checked from %0d loads, %0d integrates, %0d controlled steps",
             n_results, n_loads, n_integrates, n_controls);
    $display("Summary: %0d dropped items, %0d saturated results, %0d register settings",
             n_ignored, n_saturated, PHASES + 1);
    if (fault_count == 0) begin
      $display("damped_particle_integrator_unit test passed");
    end else begin
      $display("%0d mismatches", fault_count);
      $display("damped_particle_integrator_unit test failed");
    end
    $finish;
  end

endmodule

@@ damped_particle_integrator_unit.f @@
rtl/dpi_pkg.sv
rtl/dpi_table.sv
rtl/dpi_lane.sv
rtl/damped_particle_integrator_unit.sv
sim/damped_particle_integrator_unit_tb.sv
